// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and byte classification for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] REPL_CP = CP_W'(21'h00FFFD);

    localparam logic [2:0] LEN_BAD   = 3'd0;
    localparam logic [2:0] LEN_ASCII = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // one queue entry: one result, or a replacement followed by one result
    typedef struct packed {
        logic            two;
        logic            repl;
        logic [CP_W-1:0] cp;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_BAD;
        if (b < 8'h80)                      len = LEN_ASCII;
        else if (b inside {[8'hC2:8'hDF]}) len = LEN_TWO;
        else if (b inside {[8'hE0:8'hEF]}) len = LEN_THREE;
        else if (b inside {[8'hF0:8'hF4]}) len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 2'd1) begin
            if (lead == 8'hE0)      lo = 8'hA0;
            else if (lead == 8'hED) hi = 8'h9F;
            else if (lead == 8'hF0) lo = 8'h90;
            else if (lead == 8'hF4) hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

// ----- rtl/core/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front
// Holds the pending prefix, classifies each accepted byte and builds the
// queue entry describing the results it causes.
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output utf8d_pkg::t_push    o_push
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_pend [3];

    logic [2:0]                 lead_len;
    logic [2:0]                 plen;
    logic [2:0]                 flen;
    logic                       ext;
    logic                       complete;
    logic                       brk;
    logic                       fresh_has;
    logic                       fresh_start;
    logic [utf8d_pkg::CP_W-1:0] seq_cp;
    logic [utf8d_pkg::CP_W-1:0] fresh_cp;
    logic                       fresh_repl;

    always_comb begin
        lead_len = utf8d_pkg::seq_len(r_pend[0]);
        plen     = (lead_len < utf8d_pkg::LEN_TWO) ? utf8d_pkg::LEN_TWO : lead_len;
        ext      = (r_cnt != 2'd0) && ({1'b0, r_cnt} < plen)
                   && utf8d_pkg::cont_ok(r_pend[0], r_cnt, i_byte);
        complete = ext && (({1'b0, r_cnt} + 3'd1) == plen);
        brk      = (r_cnt != 2'd0) && !ext;

        flen        = utf8d_pkg::seq_len(i_byte);
        fresh_has   = !ext && ((flen == utf8d_pkg::LEN_ASCII) || (flen == utf8d_pkg::LEN_BAD));
        fresh_start = !ext && !fresh_has;
        fresh_repl  = (flen == utf8d_pkg::LEN_BAD);
        fresh_cp    = fresh_repl ? utf8d_pkg::REPL_CP
                                 : {{(utf8d_pkg::CP_W-8){1'b0}}, i_byte};

        case (plen)
            utf8d_pkg::LEN_TWO: begin
                seq_cp = {10'd0, r_pend[0][4:0], i_byte[5:0]};
            end
            utf8d_pkg::LEN_THREE: begin
                seq_cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], i_byte[5:0]};
            end
            default: begin
                seq_cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], i_byte[5:0]};
            end
        endcase

        o_push.push       = i_accept && (complete || brk || fresh_has);
        o_push.entry.two  = brk && fresh_has;
        o_push.entry.repl = fresh_has ? fresh_repl : !complete;
        o_push.entry.cp   = fresh_has ? fresh_cp
                                      : (complete ? seq_cp : utf8d_pkg::REPL_CP);

        if (ext && !complete) n_cnt = r_cnt + 2'd1;
        else if (fresh_start) n_cnt = 2'd1;
        else                  n_cnt = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (fresh_start) begin
                r_pend[0] <= i_byte;
            end else if (ext && !complete) begin
                case (r_cnt)
                    2'd1:    r_pend[1] <= i_byte;
                    2'd2:    r_pend[2] <= i_byte;
                    default: r_pend[0] <= r_pend[0];
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/utf8d_fifo.sv -----
// ----------------------------------------------------------------------------
// utf8d_fifo
// Short queue of result entries between the classifier and the output stage.
// ----------------------------------------------------------------------------
module utf8d_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8d_pkg::t_push  i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output utf8d_pkg::t_entry o_head
);

    utf8d_pkg::t_entry                r_mem [utf8d_pkg::FIFO_DEPTH];
    logic [utf8d_pkg::PTR_W-1:0]      r_wr_ptr;
    logic [utf8d_pkg::PTR_W-1:0]      r_rd_ptr;
    logic [utf8d_pkg::CNT_W-1:0]      r_count;
    logic [utf8d_pkg::CNT_W-1:0]      n_count;

    assign o_full  = (r_count == utf8d_pkg::CNT_W'(utf8d_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push.push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)       r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

// ----- rtl/core/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// utf8d_back
// Output register: turns queue entries into one or two result beats.
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  utf8d_pkg::t_entry           i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [utf8d_pkg::CP_W-1:0]  o_cp,
    output logic                        o_repl,
    output logic                        o_last
);

    logic                       r_valid;
    logic                       r_phase;
    logic [utf8d_pkg::CP_W-1:0] r_cp;
    logic                       r_repl;
    logic                       r_last;
    logic                       load;
    logic                       first_of_two;

    assign load         = !i_empty && (!r_valid || i_ready);
    assign first_of_two = i_head.two && !r_phase;
    assign o_pop        = load && !first_of_two;

    assign o_valid = r_valid;
    assign o_cp    = r_cp;
    assign o_repl  = r_repl;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= first_of_two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= first_of_two ? utf8d_pkg::REPL_CP : i_head.cp;
            r_repl <= first_of_two ? 1'b1 : i_head.repl;
            r_last <= !first_of_two;
        end
    end

endmodule

// ----- rtl/core/utf8_decoder_with_replacement.sv -----
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// Streaming UTF-8 decoder, strict validity, U+FFFD for ill-formed prefixes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one raw byte per beat on s_tdata. Master side gives one
//   result per beat: code point in m_tdata, replacement flag in m_tuser and
//   m_tlast on the final result caused by an input byte.
//   A byte that only extends a pending sequence gives no beat; a byte that
//   breaks a pending prefix gives U+FFFD, then, unless it opens a new
//   sequence, its own result; the final beat carries m_tlast.
//   Throughput: one byte per cycle while the queue has room; a two-result
//   byte gives two beats, which the output register drains one beat per cycle while the receiver is ready.
//   A result passes through the queue and then the output register before it appears on m_tvalid.
//   A 4-entry queue between the classifier and the output register absorbs
//   receiver stalls; s_tready drops only when that queue is full.
//   Reset clears the pending prefix, the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // [20:0] code_point, [23:21] zero
    output logic        o_m_tuser,    // [0] is_replacement
    output logic        o_m_tlast
);

    utf8d_pkg::t_push           push;
    utf8d_pkg::t_entry          head;
    logic                       full;
    logic                       empty;
    logic                       pop;
    logic                       accept;
    logic [utf8d_pkg::CP_W-1:0] cp;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tdata  = {3'd0, cp};

    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_s_tdata),
        .o_push  (push)
    );

    utf8d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cp    (cp),
        .o_repl  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

    a_second_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> (o_m_tvalid && o_m_tlast))
        else $error("second result of a byte did not follow");

    a_first_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> o_m_tuser)
        else $error("non-final result is not a replacement");

    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (cp == utf8d_pkg::REPL_CP))
        else $error("replacement result carries wrong code point");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming UTF-8 decoder with U+FFFD replacement.
// A behavioral decoder tracks the pending prefix and queues the code points
// each accepted byte should produce. Every master-side beat is compared
// against the oldest queued result. Stimulus has four parts: directed edge
// cases, random valid/truncated/corrupted sequences, gap-free streaming, and a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;

    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       repl;
        logic                       last;
    } t_cp_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;    // [20:0] code_point, [23:21] zero
    logic        o_m_tuser;    // [0] is_replacement
    logic        o_m_tlast;

    t_cp_result  expected_cps[$];
    logic [7:0]  prefix_bytes[3];
    int          prefix_len = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    bit          src_gaps = 1'b1;
    bit          snk_gaps = 1'b1;
    bit          hold_request = 1'b0;

    utf8_decoder_with_replacement dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // behavioral decoder
    // ------------------------------------------------------------------
    function automatic int lead_len(input logic [7:0] b);
        if (b < 8'h80) return 1;
        if (b >= 8'hC2 && b <= 8'hDF) return 2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3;
        if (b >= 8'hF0 && b <= 8'hF4) return 4;
        return 0;
    endfunction

    function automatic bit cont_fits(input logic [7:0] lead, input int pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (pos == 1) begin
            if (lead == 8'hE0) lo = 8'hA0;
            else if (lead == 8'hED) hi = 8'h9F;
            else if (lead == 8'hF0) lo = 8'h90;
            else if (lead == 8'hF4) hi = 8'h8F;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        t_cp_result                 made[2];
        int                         n_made;
        t_cp_result                 r;
        int                         need;
        bit                         fresh;
        logic [utf8d_pkg::CP_W-1:0] cp;
        n_made = 0;
        fresh = 1'b1;
        if (prefix_len != 0) begin
            need = lead_len(prefix_bytes[0]);
            if (need < 2) need = 2;
            if (prefix_len < need && cont_fits(prefix_bytes[0], prefix_len, b)) begin
                fresh = 1'b0;
                if (prefix_len + 1 == need) begin
                    case (need)
                        2: cp = {10'd0, prefix_bytes[0][4:0], b[5:0]};
                        3: cp = {5'd0, prefix_bytes[0][3:0], prefix_bytes[1][5:0], b[5:0]};
                        default: cp = {prefix_bytes[0][2:0], prefix_bytes[1][5:0],
                                       prefix_bytes[2][5:0], b[5:0]};
                    endcase
                    made[n_made] = '{cp: cp, repl: 1'b0, last: 1'b0};
                    n_made++;
                    prefix_len = 0;
                end else begin
                    prefix_bytes[prefix_len] = b;
                    prefix_len++;
                end
            end else begin
                made[n_made] = '{cp: utf8d_pkg::REPL_CP, repl: 1'b1, last: 1'b0};
                n_made++;
                prefix_len = 0;
            end
        end
        if (fresh) begin
            need = lead_len(b);
            if (need == 1) begin
                made[n_made] = '{cp: {13'd0, b}, repl: 1'b0, last: 1'b0};
                n_made++;
            end else if (need == 0) begin
                made[n_made] = '{cp: utf8d_pkg::REPL_CP, repl: 1'b1, last: 1'b0};
                n_made++;
            end else begin
                prefix_bytes[0] = b;
                prefix_len = 1;
            end
        end
        for (int i = 0; i < n_made; i++) begin
            r = made[i];
            r.last = (i == n_made - 1);
            expected_cps = {expected_cps, r};
        end
    endfunction

    // ------------------------------------------------------------------
    // prediction on input beats, checking on output beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_cp_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) predict_byte(i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_cps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: data=%06h user=%0b last=%0b",
                                 o_m_tdata, o_m_tuser, o_m_tlast);
                end else begin
                    want = expected_cps.pop_front();
                    if (o_m_tdata !== {3'b000, want.cp} || o_m_tuser !== want.repl ||
                        o_m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %06h/%0b/%0b got %06h/%0b/%0b",
                                     want.cp, want.repl, want.last,
                                     o_m_tdata, o_m_tuser, o_m_tlast);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_LEN;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!snk_gaps) begin
                i_m_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_m_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_cps.size() != 0) @(posedge i_clk);
    endtask

    function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] seq);
        seq = '0;
        if (cp < 21'h80) begin
            seq[7:0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            seq[7:0]  = {3'b110, cp[10:6]};
            seq[15:8] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            seq[7:0]   = {4'b1110, cp[15:12]};
            seq[15:8]  = {2'b10, cp[11:6]};
            seq[23:16] = {2'b10, cp[5:0]};
            return 3;
        end
        seq[7:0]   = {5'b11110, cp[20:18]};
        seq[15:8]  = {2'b10, cp[17:12]};
        seq[23:16] = {2'b10, cp[11:6]};
        seq[31:24] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic logic [20:0] rand_scalar();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                do cp = 21'($urandom_range('h800, 'hFFFF));
                while (cp >= 21'hD800 && cp <= 21'hDFFF);
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h7F, 8'h80, 8'hC0, 8'hF5, 8'hFF,   // ASCII ends, lone bad bytes
                8'hC2, 8'h80,                               // U+0080
                8'hE0, 8'h9F,                               // E0 range break, stray cont
                8'hED, 8'hA0,                               // surrogate break
                8'hEF, 8'hBF, 8'hBD,                        // well-formed U+FFFD
                8'hF0, 8'h8F,                               // overlong 4-byte break
                8'hF4, 8'h8F, 8'hBF, 8'hBF,                 // U+10FFFF
                8'hF4, 8'h90,                               // above range
                8'hE1, 8'h41,                               // break into ASCII
                8'hC3, 8'hE2, 8'h82, 8'hAC};                // break into new lead
        foreach (seq[i]) send_byte(seq[i]);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_random_stream(input int n_bytes);
        logic [31:0] enc;
        int          len;
        int          keep;
        int          r;
        int          stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_byte(8'($urandom));
            end else begin
                len = utf8_encode(rand_scalar(), enc);
                keep = len;
                if (r < 22 && len > 1) begin
                    keep = $urandom_range(1, len - 1);
                end else if (r < 32 && len > 1) begin
                    enc[8 * $urandom_range(1, len - 1) +: 8] = 8'($urandom);
                end
                for (int k = 0; k < keep; k++) send_byte(enc[8 * k +: 8]);
            end
        end
        drop_valid();
        wait_drained();
    endtask

    task automatic test_no_gaps(input int n_bytes);
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        test_random_stream(n_bytes);
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
    endtask

    task automatic test_backpressure(input int n_bytes);
        src_gaps = 1'b0;
        hold_request = 1'b1;
        test_random_stream(n_bytes);
        src_gaps = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream(1100);
        test_no_gaps(300);
        test_backpressure(150);
        test_random_stream(450);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_cps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_fifo.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_decoder_with_replacement.sv
test/tb.sv
